// ===== design/rttm_pkg.sv =====
`timescale 1ns / 1ps

package rttm_pkg;

    localparam int CFG_W  = 5;
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 63;
    localparam int RT_W   = 64;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    // event kinds carried on tuser
    localparam logic ACT_REQUEST  = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_TREAD,
        ST_RESULT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;      // latch the incoming word, clear scan trackers
        logic scan_rd;   // read both seq stores at the scan address
        logic time_rd;   // read time stores at the hit index
        logic out_load;  // load result register, free the matched entry
        logic commit;    // evict if full, store into own table
    } cmd_t;

    typedef struct packed {
        logic hit;       // opposite table holds the sequence number
        logic out_free;  // result register can take a word this cycle
    } sts_t;

endpackage

// ===== design/rttm_ram.sv =====
`timescale 1ns / 1ps

module rttm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rttm_ctrl.sv =====
`timescale 1ns / 1ps

module rttm_ctrl #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rttm_pkg::sts_t      sts,
    output rttm_pkg::cmd_t      cmd,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] scan_addr
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    rttm_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    addr_reg, addr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rttm_pkg::ST_IDLE;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            rttm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    addr_next  = '0;
                    state_next = rttm_pkg::ST_SCAN;
                end
            end
            rttm_pkg::ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (addr_reg == LAST_IDX) begin
                    state_next = rttm_pkg::ST_DRAIN;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            rttm_pkg::ST_DRAIN: begin
                // last compare lands this cycle
                state_next = rttm_pkg::ST_DECIDE;
            end
            rttm_pkg::ST_DECIDE: begin
                state_next = sts.hit ? rttm_pkg::ST_TREAD : rttm_pkg::ST_COMMIT;
            end
            rttm_pkg::ST_TREAD: begin
                cmd.time_rd = 1'b1;
                state_next  = rttm_pkg::ST_RESULT;
            end
            rttm_pkg::ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = rttm_pkg::ST_IDLE;
                end
            end
            rttm_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = rttm_pkg::ST_IDLE;
            end
            default: begin
                state_next = rttm_pkg::ST_IDLE;
            end
        endcase
    end

    assign scan_addr = addr_reg;

endmodule

// ===== design/rttm_dp.sv =====
`timescale 1ns / 1ps

module rttm_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rttm_pkg::cmd_t                    cmd,
    output rttm_pkg::sts_t                    sts,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] scan_addr,
    input  logic [95:0]                       s_tdata,
    input  logic                              s_tuser,
    input  logic [rttm_pkg::CFG_W-1:0]        entries_in_use,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [95:0]                       m_tdata
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > rttm_pkg::CFG_W) ? CW : rttm_pkg::CFG_W;
    localparam int SW   = rttm_pkg::SEQ_W;
    localparam int TW   = rttm_pkg::TIME_W;
    localparam int RW   = rttm_pkg::RT_W;

    // latched event
    logic          act_reg;
    logic [SW-1:0] seq_reg;
    logic [TW-1:0] time_reg;

    // table state
    logic [TABLE_DEPTH-1:0] req_valid_reg, req_valid_next;
    logic [TABLE_DEPTH-1:0] resp_valid_reg, resp_valid_next;
    logic [CW-1:0]          req_cnt_reg, req_cnt_next;
    logic [CW-1:0]          resp_cnt_reg, resp_cnt_next;

    // scan compare stage
    logic          cmp_en_reg;
    logic [IW-1:0] cmp_idx_reg;

    // scan trackers
    logic          hit_found_reg, find_found_reg, min_found_reg, free_found_reg;
    logic [IW-1:0] hit_idx_reg, find_idx_reg, min_idx_reg, free_idx_reg;
    logic [SW-1:0] min_seq_reg;

    // result register
    logic          out_valid_reg;
    logic [SW-1:0] out_seq_reg;
    logic [RW-1:0] out_rt_reg;

    logic [SW-1:0] req_seq_q, resp_seq_q, own_seq_q, oth_seq_q;
    logic [TW-1:0] req_time_q, resp_time_q;
    logic          own_v, oth_v;

    logic [CMPW-1:0] lim, own_cnt_ext;
    logic [CW-1:0]   own_cnt;
    logic            evict, keep;
    logic [IW-1:0]   slot;
    logic [RW-1:0]   rt;

    // ---------------- stores ----------------
    rttm_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_req_seq (
        .aclk(aclk), .we(cmd.commit && (act_reg == rttm_pkg::ACT_REQUEST)),
        .waddr(slot), .wdata(seq_reg),
        .re(cmd.scan_rd), .raddr(scan_addr), .rdata(req_seq_q)
    );
    rttm_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_req_time (
        .aclk(aclk), .we(cmd.commit && (act_reg == rttm_pkg::ACT_REQUEST)),
        .waddr(slot), .wdata(time_reg),
        .re(cmd.time_rd), .raddr(hit_idx_reg), .rdata(req_time_q)
    );
    rttm_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_resp_seq (
        .aclk(aclk), .we(cmd.commit && (act_reg == rttm_pkg::ACT_RESPONSE)),
        .waddr(slot), .wdata(seq_reg),
        .re(cmd.scan_rd), .raddr(scan_addr), .rdata(resp_seq_q)
    );
    rttm_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_resp_time (
        .aclk(aclk), .we(cmd.commit && (act_reg == rttm_pkg::ACT_RESPONSE)),
        .waddr(slot), .wdata(time_reg),
        .re(cmd.time_rd), .raddr(hit_idx_reg), .rdata(resp_time_q)
    );

    // own table is the one the event goes into; the other is searched for a match
    always_comb begin
        if (act_reg == rttm_pkg::ACT_RESPONSE) begin
            own_seq_q  = resp_seq_q;
            oth_seq_q  = req_seq_q;
            own_v      = resp_valid_reg[cmp_idx_reg];
            oth_v      = req_valid_reg[cmp_idx_reg];
            own_cnt    = resp_cnt_reg;
            rt         = {1'b0, time_reg} - {1'b0, req_time_q};
        end else begin
            own_seq_q  = req_seq_q;
            oth_seq_q  = resp_seq_q;
            own_v      = req_valid_reg[cmp_idx_reg];
            oth_v      = resp_valid_reg[cmp_idx_reg];
            own_cnt    = req_cnt_reg;
            rt         = {1'b0, resp_time_q} - {1'b0, time_reg};
        end
    end

    // clamp limit to 1..TABLE_DEPTH
    always_comb begin
        lim = CMPW'(entries_in_use);
        if (entries_in_use == '0) begin
            lim = CMPW'(1);
        end else if (lim > CMPW'(TABLE_DEPTH)) begin
            lim = CMPW'(TABLE_DEPTH);
        end
        own_cnt_ext = CMPW'(own_cnt);
        evict       = (own_cnt_ext >= lim);
        // existing entry is reused unless it is the one being evicted
        keep        = find_found_reg && !(evict && (find_idx_reg == min_idx_reg));
        if (keep) begin
            slot = find_idx_reg;
        end else if (evict) begin
            slot = min_idx_reg;
        end else begin
            slot = free_idx_reg;
        end
    end

    // ---------------- scan ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_rd;
        end
        cmp_idx_reg <= scan_addr;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg        <= s_tuser;
            seq_reg        <= s_tdata[SW-1:0];
            time_reg       <= s_tdata[SW+TW-1:SW];
            hit_found_reg  <= 1'b0;
            find_found_reg <= 1'b0;
            min_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmp_en_reg) begin
            if (oth_v && (oth_seq_q == seq_reg) && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= cmp_idx_reg;
            end
            if (own_v && (own_seq_q == seq_reg) && !find_found_reg) begin
                find_found_reg <= 1'b1;
                find_idx_reg   <= cmp_idx_reg;
            end
            if (own_v && (!min_found_reg || (own_seq_q < min_seq_reg))) begin
                min_found_reg <= 1'b1;
                min_idx_reg   <= cmp_idx_reg;
                min_seq_reg   <= own_seq_q;
            end
            if (!own_v && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end
    end

    // ---------------- valid bits and counts ----------------
    always_comb begin
        req_valid_next  = req_valid_reg;
        resp_valid_next = resp_valid_reg;
        req_cnt_next    = req_cnt_reg;
        resp_cnt_next   = resp_cnt_reg;
        if (cmd.commit) begin
            if (act_reg == rttm_pkg::ACT_RESPONSE) begin
                if (evict) begin
                    resp_valid_next[min_idx_reg] = 1'b0;
                end
                resp_valid_next[slot] = 1'b1;
                resp_cnt_next = resp_cnt_reg - CW'(evict) + CW'(!keep);
            end else begin
                if (evict) begin
                    req_valid_next[min_idx_reg] = 1'b0;
                end
                req_valid_next[slot] = 1'b1;
                req_cnt_next = req_cnt_reg - CW'(evict) + CW'(!keep);
            end
        end
        if (cmd.out_load) begin
            if (act_reg == rttm_pkg::ACT_RESPONSE) begin
                req_valid_next[hit_idx_reg] = 1'b0;
                req_cnt_next = req_cnt_reg - CW'(1);
            end else begin
                resp_valid_next[hit_idx_reg] = 1'b0;
                resp_cnt_next = resp_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg  <= '0;
            resp_valid_reg <= '0;
            req_cnt_reg    <= '0;
            resp_cnt_reg   <= '0;
        end else begin
            req_valid_reg  <= req_valid_next;
            resp_valid_reg <= resp_valid_next;
            req_cnt_reg    <= req_cnt_next;
            resp_cnt_reg   <= resp_cnt_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_seq_reg <= seq_reg;
            out_rt_reg  <= rt;
        end
    end

    assign sts.hit      = hit_found_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {out_rt_reg, out_seq_reg};

endmodule

// ===== design/rtt_request_response_matcher_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-----------------------------------------------
// s_        | in  | s_tvalid/s_tready  | tuser: action; tdata: event_seq, event_time
// m_        | out | m_tvalid/m_tready  | tdata: matched_seq, round_trip
// APB       | in  | psel/penable       | reg 0 @ 0x0: entries_in_use[4:0]
//
// Between one accepted word and the next accept, a linear scan reads both seq
// stores one entry a cycle, then drain, decide and commit on a miss, or drain,
// decide, time read and result on a match.
// Reset clears both tables' valid bits and counts at once; no clearing pass.
// A finished result waits in the output register; new words are taken meanwhile,
// and only the next match stalls in its result state until that register drains.

module rtt_request_response_matcher_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] event_seq, [94:32] event_time, [95] zero
    input  logic        s_tuser,   // [0] action: 0 request, 1 response

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] matched_seq, [95:32] round_trip

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    rttm_pkg::cmd_t cmd;
    rttm_pkg::sts_t sts;
    logic [IW-1:0]  scan_addr;

    // config register
    logic [rttm_pkg::CFG_W-1:0] entries_reg;
    logic                       reg_hit;

    assign reg_hit = (paddr[2:2] == rttm_pkg::REG_ENTRIES_IN_USE);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= rttm_pkg::ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            entries_reg <= pwdata[rttm_pkg::CFG_W-1:0];
        end
    end

    // the low paddr bits only pick a byte; reads decode the word index
    assign prdata = reg_hit ? {{(32 - rttm_pkg::CFG_W){1'b0}}, entries_reg} : '0;

    rttm_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    rttm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .scan_addr      (scan_addr),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .entries_in_use (entries_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
